// ===== rtl/core/hrhp_pkg.sv =====
`timescale 1ns / 1ps
package hrhp_pkg;

  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_BODY   = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [1:0] METH_GET  = 2'd0;
  localparam logic [1:0] METH_POST = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;
  localparam logic [1:0] METH_UNK  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BADLINE = 2'd1;
  localparam logic [1:0] STAT_NOEOL   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef enum logic [3:0] {
    PH_LINE = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // method match: 0 start, 1..12 word*4+pos, 15 dead
  localparam logic [3:0] MM_DEAD = 4'd15;

  localparam logic [3:0] VS_MAJ1 = 4'd5;
  localparam logic [3:0] VS_MAJ  = 4'd6;
  localparam logic [3:0] VS_MIN1 = 4'd7;
  localparam logic [3:0] VS_MIN  = 4'd8;
  localparam logic [3:0] VS_END  = 4'd9;
  localparam logic [3:0] VS_BAD  = 4'd10;

  // one result record
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  meth;
    logic [7:0]  vmaj;
    logic [7:0]  vmin;
    logic [15:0] soff;
    logic [15:0] slen;
    logic [15:0] voff;
    logic [15:0] vlen;
    logic [4:0]  hidx;
    logic [1:0]  stat;
    logic        last;
  } rec_t;

  function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {4'd0, acc} * 12'd10 + {4'd0, c - 8'h30};
    acc_digit = (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] meth_char(input logic [3:0] mm);
    case (mm)
      4'd1:    meth_char = "E";
      4'd2:    meth_char = "T";
      4'd5:    meth_char = "O";
      4'd6:    meth_char = "S";
      4'd7:    meth_char = "T";
      4'd9:    meth_char = "E";
      4'd10:   meth_char = "A";
      4'd11:   meth_char = "D";
      default: meth_char = 8'h00;
    endcase
  endfunction

  function automatic logic [1:0] meth_code(input logic [3:0] mm);
    case (mm)
      4'd3:    meth_code = METH_GET;
      4'd8:    meth_code = METH_POST;
      4'd12:   meth_code = METH_HEAD;
      default: meth_code = METH_UNK;
    endcase
  endfunction

  function automatic logic [7:0] http_char(input logic [3:0] vs);
    case (vs)
      4'd0:    http_char = "H";
      4'd1:    http_char = "T";
      4'd2:    http_char = "T";
      4'd3:    http_char = "P";
      4'd4:    http_char = "/";
      default: http_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/core/hrhp_outq.sv =====
`timescale 1ns / 1ps
module hrhp_outq
  import hrhp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  logic [1:0] push_cnt,
  input  rec_t push_a,
  input  rec_t push_b,
  output logic pop_valid,
  input  logic pop_ready,
  output rec_t pop_data
);

  // four-entry record queue; accepts a group when two slots are free
  rec_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r <= 3'd2);
  assign push       = push_valid && push_ready;
  assign pop_valid  = (cnt_r != 3'd0);
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + push_cnt : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + (push ? {1'b0, push_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (push && push_cnt != 2'd0) mem_r[wp_r] <= push_a;
    if (push && push_cnt == 2'd2) mem_r[wp_r + 2'd1] <= push_b;
  end

endmodule

// ===== rtl/core/http_request_header_parser_core.sv =====
`timescale 1ns / 1ps
// HTTP/1.1 request header parser. Takes one request byte per cycle and
// produces request-line, header, body-start and finish records. The parser
// state registers and the byte on the input port feed one pass of
// combinational logic that writes the byte's records into a four-entry queue
// at the accepting edge. With the result side ready a byte is accepted every
// cycle, and its records leave the queue in order behind any queued ahead. The
// queue takes a byte only while at least two slots are free, so result stalls
// hold off the input. A byte that causes two records (a line end together
// with last_byte) pushes both into the queue together.
module http_request_header_parser_core
  import hrhp_pkg::*;
#(
  parameter int URI_MAX     = 256,
  parameter int HEADER_MAX  = 32,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [1:0]  out_method_code,
  output logic [7:0]  out_http_major,
  output logic [7:0]  out_http_minor,
  output logic [15:0] out_span_offset,
  output logic [15:0] out_span_length,
  output logic [15:0] out_value_offset,
  output logic [15:0] out_value_length,
  output logic [4:0]  out_header_index,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);

  localparam int OB = OFFSET_BITS;
  localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
  localparam logic [OB-1:0] ULIM = OB'(URI_MAX - 1);

  // parser state
  phase_t        phase_r, phase_nxt;
  logic [OB-1:0] boff_r, boff_nxt;
  logic [1:0]    tcnt_r, tcnt_nxt, ctok_r, ctok_nxt;
  logic          intok_r, intok_nxt;
  logic [3:0]    mm_r, mm_nxt, vs_r, vs_nxt;
  logic [OB-1:0] ustart_r, ustart_nxt, ulen_r, ulen_nxt;
  logic [7:0]    maj_r, maj_nxt, min_r, min_nxt;
  logic [OB-1:0] lstart_r, lstart_nxt, colon_r, colon_nxt, vstart_r, vstart_nxt;
  logic          cseen_r, cseen_nxt, skip_r, skip_nxt, nonempty_r, nonempty_nxt;
  logic [5:0]    hcnt_r, hcnt_nxt;
  logic          pcr_r, pcr_nxt, bvalid_r, bvalid_nxt;
  logic [OB-1:0] body_r, body_nxt;
  logic          err_r, err_nxt;

  logic [1:0] q_cnt;
  rec_t       rec_a, rec_b, q_out;
  logic       q_ready, acc;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;

  function automatic logic [OB-1:0] sinc(input logic [OB-1:0] v);
    sinc = (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] lo16(input logic [OB-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    lo16 = w[15:0];
  endfunction

  // single-pass next state and records for one byte
  always_comb begin
    logic [OB-1:0] pos, cpos, fpos, total;
    logic [7:0]    c, fc;
    logic          do_feed, dig, sp, reset_all;
    rec_t          r, fin;
    logic [1:0]    n;

    phase_nxt = phase_r; boff_nxt = boff_r; tcnt_nxt = tcnt_r; ctok_nxt = ctok_r;
    intok_nxt = intok_r; mm_nxt = mm_r; vs_nxt = vs_r; ustart_nxt = ustart_r;
    ulen_nxt = ulen_r; maj_nxt = maj_r; min_nxt = min_r; lstart_nxt = lstart_r;
    colon_nxt = colon_r; vstart_nxt = vstart_r; cseen_nxt = cseen_r;
    skip_nxt = skip_r; nonempty_nxt = nonempty_r; hcnt_nxt = hcnt_r;
    pcr_nxt = pcr_r; bvalid_nxt = bvalid_r; body_nxt = body_r; err_nxt = err_r;
    c = in_data_byte; pos = boff_r;
    cpos = (pos != '0) ? pos - 1'b1 : '0;
    r = '0; fin = '0; n = 2'd0;
    do_feed = 1'b0; fc = c; fpos = pos;
    total = sinc(pos);
    reset_all = 1'b0;

    if (phase_r == PH_LINE || phase_r == PH_HDR) begin
      if (pcr_r && c == CH_LF) begin
        pcr_nxt = 1'b0;
        if (phase_r == PH_LINE) begin
          if (tcnt_r == 2'd3 && (vs_r == VS_MIN || vs_r == VS_END)) begin
            r.kind = KIND_LINE; r.meth = meth_code(mm_r);
            r.vmaj = maj_r; r.vmin = min_r;
            r.soff = lo16(ustart_r); r.slen = lo16(ulen_r);
            n = 2'd1;
            phase_nxt = PH_HDR;
            lstart_nxt = sinc(pos); cseen_nxt = 1'b0; colon_nxt = '0;
            vstart_nxt = '0; skip_nxt = 1'b0; nonempty_nxt = 1'b0;
          end else begin
            err_nxt = 1'b1; phase_nxt = PH_DONE;
          end
        end else if (!nonempty_r) begin
          bvalid_nxt = 1'b1; body_nxt = sinc(pos);
          r.kind = KIND_BODY; r.soff = lo16(sinc(pos));
          n = 2'd1;
          phase_nxt = PH_BODY;
        end else begin
          if (cseen_r && {26'd0, hcnt_r} < 32'(HEADER_MAX)) begin
            r.kind = KIND_HEADER; r.soff = lo16(lstart_r);
            r.slen = lo16((colon_r > lstart_r) ? colon_r - lstart_r : '0);
            r.voff = lo16(vstart_r);
            r.vlen = lo16((cpos > vstart_r) ? cpos - vstart_r : '0);
            r.hidx = hcnt_r[4:0];
            n = 2'd1;
            hcnt_nxt = hcnt_r + 6'd1;
          end
          lstart_nxt = sinc(pos); cseen_nxt = 1'b0; colon_nxt = '0;
          vstart_nxt = '0; skip_nxt = 1'b0; nonempty_nxt = 1'b0;
        end
      end else if (pcr_r) begin
        // held CR is content; only a CR then CR keeps one pending
        pcr_nxt = (c == CH_CR);
        do_feed = 1'b1; fc = CH_CR; fpos = cpos;
      end else if (c == CH_CR) begin
        pcr_nxt = 1'b1;
      end else begin
        do_feed = 1'b1;
      end
    end

    // a lone CR followed by a normal byte feeds both; lines have no CR
    // sensitivity in content so feed the CR then the byte
    if (do_feed) begin
      for (int k = 0; k < 2; k++) begin
        logic       go;
        logic [7:0] ch;
        logic [OB-1:0] p;
        go = (k == 0) ? 1'b1 : (pcr_r && c != CH_CR);
        ch = (k == 0) ? fc : c;
        p  = (k == 0) ? fpos : pos;
        dig = (ch >= "0" && ch <= "9");
        sp  = (ch == CH_SP);
        if (go && phase_r == PH_LINE) begin
          if (sp) begin
            intok_nxt = 1'b0;
          end else begin
            if (!intok_nxt) begin
              intok_nxt = 1'b1;
              if (tcnt_nxt != 2'd3) begin
                ctok_nxt = tcnt_nxt; tcnt_nxt = tcnt_nxt + 2'd1;
              end else begin
                ctok_nxt = 2'd3;
              end
              if (ctok_nxt == 2'd1) begin
                ustart_nxt = p; ulen_nxt = '0;
              end
            end
            case (ctok_nxt)
              2'd0: begin
                if (mm_nxt == 4'd0) begin
                  mm_nxt = (ch == "G") ? 4'd1 : (ch == "P") ? 4'd5 :
                           (ch == "H") ? 4'd9 : MM_DEAD;
                end else if (mm_nxt != MM_DEAD) begin
                  mm_nxt = (meth_char(mm_nxt) != 8'h00 && ch == meth_char(mm_nxt)) ?
                           mm_nxt + 4'd1 : MM_DEAD;
                end
              end
              2'd1: begin
                if (ulen_nxt < ULIM) ulen_nxt = ulen_nxt + 1'b1;
              end
              2'd2: begin
                if (vs_nxt < 4'd5) begin
                  vs_nxt = (ch == http_char(vs_nxt)) ? vs_nxt + 4'd1 : VS_BAD;
                end else if (vs_nxt == VS_MAJ1) begin
                  if (dig) begin maj_nxt = acc_digit(maj_nxt, ch); vs_nxt = VS_MAJ; end
                  else vs_nxt = VS_BAD;
                end else if (vs_nxt == VS_MAJ) begin
                  if (dig) maj_nxt = acc_digit(maj_nxt, ch);
                  else vs_nxt = (ch == CH_DOT) ? VS_MIN1 : VS_BAD;
                end else if (vs_nxt == VS_MIN1) begin
                  if (dig) begin min_nxt = acc_digit(min_nxt, ch); vs_nxt = VS_MIN; end
                  else vs_nxt = VS_BAD;
                end else if (vs_nxt == VS_MIN) begin
                  if (!dig) vs_nxt = VS_END;
                  else min_nxt = acc_digit(min_nxt, ch);
                end
              end
              default: ;
            endcase
          end
        end else if (go && phase_r == PH_HDR) begin
          nonempty_nxt = 1'b1;
          if (!cseen_nxt && ch == CH_COLON) begin
            cseen_nxt = 1'b1; colon_nxt = p; vstart_nxt = sinc(p); skip_nxt = 1'b1;
          end else if (skip_nxt) begin
            if (sp) vstart_nxt = sinc(p);
            else skip_nxt = 1'b0;
          end
        end
      end
    end

    boff_nxt = sinc(pos);

    // finish record
    if (in_last_byte) begin
      fin.kind = KIND_FINISH;
      fin.stat = (phase_nxt == PH_DONE) ? (err_nxt ? STAT_BADLINE : STAT_OK) :
                 (phase_nxt == PH_LINE) ? STAT_NOEOL : STAT_OK;
      if (bvalid_nxt) begin
        fin.soff = lo16(body_nxt);
        fin.slen = lo16((total > body_nxt) ? total - body_nxt : '0);
      end
      fin.last = 1'b1;
      reset_all = 1'b1;
      if (n == 2'd0) begin
        rec_a = fin; rec_b = '0; q_cnt = 2'd1;
      end else begin
        rec_a = r; rec_b = fin; q_cnt = 2'd2;
      end
    end else begin
      r.last = 1'b1;
      rec_a = r; rec_b = '0; q_cnt = n;
    end

    if (reset_all) begin
      phase_nxt = PH_LINE; boff_nxt = '0; tcnt_nxt = '0; ctok_nxt = '0;
      intok_nxt = 1'b0; mm_nxt = '0; vs_nxt = '0; ustart_nxt = '0; ulen_nxt = '0;
      maj_nxt = '0; min_nxt = '0; lstart_nxt = '0; colon_nxt = '0; vstart_nxt = '0;
      cseen_nxt = 1'b0; skip_nxt = 1'b0; nonempty_nxt = 1'b0; hcnt_nxt = '0;
      pcr_nxt = 1'b0; bvalid_nxt = 1'b0; body_nxt = '0; err_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE; boff_r <= '0; tcnt_r <= '0; ctok_r <= '0;
      intok_r <= 1'b0; mm_r <= '0; vs_r <= '0; ustart_r <= '0; ulen_r <= '0;
      maj_r <= '0; min_r <= '0; lstart_r <= '0; colon_r <= '0; vstart_r <= '0;
      cseen_r <= 1'b0; skip_r <= 1'b0; nonempty_r <= 1'b0; hcnt_r <= '0;
      pcr_r <= 1'b0; bvalid_r <= 1'b0; body_r <= '0; err_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; boff_r <= boff_nxt; tcnt_r <= tcnt_nxt;
      ctok_r <= ctok_nxt; intok_r <= intok_nxt; mm_r <= mm_nxt; vs_r <= vs_nxt;
      ustart_r <= ustart_nxt; ulen_r <= ulen_nxt; maj_r <= maj_nxt; min_r <= min_nxt;
      lstart_r <= lstart_nxt; colon_r <= colon_nxt; vstart_r <= vstart_nxt;
      cseen_r <= cseen_nxt; skip_r <= skip_nxt; nonempty_r <= nonempty_nxt;
      hcnt_r <= hcnt_nxt; pcr_r <= pcr_nxt; bvalid_r <= bvalid_nxt;
      body_r <= body_nxt; err_r <= err_nxt;
    end
  end

  // record queue
  hrhp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (q_ready),
    .push_cnt   (q_cnt),
    .push_a     (rec_a),
    .push_b     (rec_b),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (q_out)
  );

  assign out_record_kind   = q_out.kind;
  assign out_method_code   = q_out.meth;
  assign out_http_major    = q_out.vmaj;
  assign out_http_minor    = q_out.vmin;
  assign out_span_offset   = q_out.soff;
  assign out_span_length   = q_out.slen;
  assign out_value_offset  = q_out.voff;
  assign out_value_length  = q_out.vlen;
  assign out_header_index  = q_out.hidx;
  assign out_status        = q_out.stat;
  assign out_last_of_run   = q_out.last;

endmodule

// ===== bench/http_request_header_parser_checker.sv =====
`timescale 1ns / 1ps
module http_request_header_parser_checker
  import hrhp_pkg::*;
#(
  parameter int URI_MAX = 256,
  parameter int HEADER_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_record_kind,
  input  logic [1:0]  out_method_code,
  input  logic [7:0]  out_http_major,
  input  logic [7:0]  out_http_minor,
  input  logic [15:0] out_span_offset,
  input  logic [15:0] out_span_length,
  input  logic [15:0] out_value_offset,
  input  logic [15:0] out_value_length,
  input  logic [4:0]  out_header_index,
  input  logic [1:0]  out_status,
  input  logic        out_last_of_run,
  output int          errors,
  output int          pending,
  output int          records_seen,
  output int          headers_seen,
  output int          buffers_seen
);

  localparam int OFF_MAX = 65535;
  localparam logic [3:0] MM_START = 4'd0;
  localparam logic [3:0] VS_H = 4'd0;

  string meth_words[3] = '{"GET", "POST", "HEAD"};
  string http_word = "HTTP/";

  // parser state mirror
  phase_t     ph;
  int         byte_pos;
  int         tok_count;
  int         cur_tok;
  bit         in_tok;
  logic [3:0] mm;
  int         uri_st;
  int         uri_len;
  logic [3:0] vs;
  int         vmaj;
  int         vmin;
  int         line_st;
  bit         colon_seen;
  int         colon_pos;
  int         val_st;
  bit         skip_sp;
  bit         line_used;
  int         hdr_count;
  bit         prev_cr;
  bit         body_seen;
  int         body_off;
  logic [1:0] err_stat;

  rec_t expected_recs[$];

  function automatic int sat_inc(int v);
    return (v < OFF_MAX) ? v + 1 : OFF_MAX;
  endfunction

  function automatic int diff0(int a, int b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int add_digit(int acc, logic [7:0] c);
    int v;
    v = acc * 10 + (c - 8'h30);
    return (v > 255) ? 255 : v;
  endfunction

  task automatic start_line(int st);
    line_st = st;
    colon_seen = 0;
    colon_pos = 0;
    val_st = 0;
    skip_sp = 0;
    line_used = 0;
  endtask

  task automatic clear_parser();
    ph = PH_LINE;
    byte_pos = 0;
    tok_count = 0;
    cur_tok = 0;
    in_tok = 0;
    mm = MM_START;
    uri_st = 0;
    uri_len = 0;
    vs = VS_H;
    vmaj = 0;
    vmin = 0;
    start_line(0);
    hdr_count = 0;
    prev_cr = 0;
    body_seen = 0;
    body_off = 0;
    err_stat = STAT_OK;
  endtask

  // method word tracking
  task automatic method_char(logic [7:0] c);
    int w;
    int p;
    if (mm == MM_START) begin
      mm = MM_DEAD;
      for (w = 0; w < 3; w++)
        if (c == meth_words[w][0]) mm = 4'(w * 4 + 1);
    end else if (mm != MM_DEAD) begin
      w = (mm - 1) / 4;
      p = mm - w * 4;
      if (p < meth_words[w].len() && c == meth_words[w][p]) mm = mm + 4'd1;
      else mm = MM_DEAD;
    end
  endtask

  function automatic logic [1:0] method_of();
    int w;
    int p;
    if (mm == MM_START || mm == MM_DEAD) return METH_UNK;
    w = (mm - 1) / 4;
    p = mm - w * 4;
    if (p == meth_words[w].len()) return w[1:0];
    return METH_UNK;
  endfunction

  // version text
  task automatic version_char(logic [7:0] c);
    bit dig;
    dig = (c >= "0" && c <= "9");
    if (vs < VS_MAJ1) begin
      vs = (c == http_word[vs]) ? vs + 4'd1 : VS_BAD;
    end else begin
      case (vs)
        VS_MAJ1: if (dig) begin
          vmaj = add_digit(vmaj, c);
          vs = VS_MAJ;
        end else vs = VS_BAD;
        VS_MAJ: if (dig) vmaj = add_digit(vmaj, c);
          else vs = (c == CH_DOT) ? VS_MIN1 : VS_BAD;
        VS_MIN1: if (dig) begin
          vmin = add_digit(vmin, c);
          vs = VS_MIN;
        end else vs = VS_BAD;
        VS_MIN: if (dig) vmin = add_digit(vmin, c);
          else vs = VS_END;
        default: ;
      endcase
    end
  endtask

  task automatic content_char(logic [7:0] c, int pos);
    if (ph == PH_LINE) begin
      if (c == CH_SP) begin
        in_tok = 0;
      end else begin
        if (!in_tok) begin
          in_tok = 1;
          if (tok_count < 3) begin
            cur_tok = tok_count;
            tok_count++;
          end else cur_tok = 3;
          if (cur_tok == 1) begin
            uri_st = pos;
            uri_len = 0;
          end
        end
        case (cur_tok)
          0: method_char(c);
          1: if (uri_len < URI_MAX - 1) uri_len++;
          2: version_char(c);
          default: ;
        endcase
      end
    end else if (ph == PH_HDR) begin
      line_used = 1;
      if (!colon_seen && c == CH_COLON) begin
        colon_seen = 1;
        colon_pos = pos;
        val_st = sat_inc(pos);
        skip_sp = 1;
      end else if (skip_sp) begin
        if (c == CH_SP) val_st = sat_inc(pos);
        else skip_sp = 0;
      end
    end
  endtask

  // work out the records one item causes
  task automatic predict_item(logic [7:0] c, logic last);
    int   pos;
    int   n;
    rec_t r;
    pos = byte_pos;
    n = 0;
    if (ph == PH_LINE || ph == PH_HDR) begin
      if (prev_cr && c == CH_LF) begin
        prev_cr = 0;
        if (ph == PH_LINE) begin
          if (tok_count == 3 && (vs == VS_MIN || vs == VS_END)) begin
            r = '0;
            r.kind = KIND_LINE;
            r.meth = method_of();
            r.vmaj = vmaj[7:0];
            r.vmin = vmin[7:0];
            r.soff = uri_st[15:0];
            r.slen = uri_len[15:0];
            expected_recs.push_back(r);
            n++;
            ph = PH_HDR;
            start_line(sat_inc(pos));
          end else begin
            err_stat = STAT_BADLINE;
            ph = PH_DONE;
          end
        end else if (!line_used) begin
          body_seen = 1;
          body_off = sat_inc(pos);
          r = '0;
          r.kind = KIND_BODY;
          r.soff = body_off[15:0];
          expected_recs.push_back(r);
          n++;
          ph = PH_BODY;
        end else begin
          if (colon_seen && hdr_count < HEADER_MAX) begin
            r = '0;
            r.kind = KIND_HEADER;
            r.soff = line_st[15:0];
            r.slen = 16'(diff0(colon_pos, line_st));
            r.voff = val_st[15:0];
            r.vlen = 16'(diff0((pos > 0) ? pos - 1 : 0, val_st));
            r.hidx = hdr_count[4:0];
            expected_recs.push_back(r);
            n++;
            hdr_count++;
          end
          start_line(sat_inc(pos));
        end
      end else begin
        // a carriage return not followed by line feed is content
        if (prev_cr) begin
          prev_cr = 0;
          content_char(CH_CR, (pos > 0) ? pos - 1 : 0);
        end
        if (c == CH_CR) prev_cr = 1;
        else content_char(c, pos);
      end
    end
    byte_pos = sat_inc(pos);
    if (last) begin
      r = '0;
      r.kind = KIND_FINISH;
      if (ph == PH_DONE) r.stat = err_stat;
      else if (ph == PH_LINE) r.stat = STAT_NOEOL;
      else r.stat = STAT_OK;
      if (body_seen) begin
        r.soff = body_off[15:0];
        r.slen = 16'(diff0(sat_inc(pos), body_off));
      end
      expected_recs.push_back(r);
      n++;
      buffers_seen++;
      clear_parser();
    end
    if (n > 0) expected_recs[$].last = 1'b1;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // compare one result item with the oldest expectation
  task automatic check_record();
    rec_t e;
    if (expected_recs.size() == 0) begin
      errors++;
      $display("%0t: unexpected record, expected none, actual kind %0d", $time,
               out_record_kind);
    end else begin
      e = expected_recs.pop_front();
      records_seen++;
      if (e.kind == KIND_HEADER) headers_seen++;
      check_field("record_kind", e.kind, out_record_kind);
      check_field("method_code", e.meth, out_method_code);
      check_field("http_major", e.vmaj, out_http_major);
      check_field("http_minor", e.vmin, out_http_minor);
      check_field("span_offset", e.soff, out_span_offset);
      check_field("span_length", e.slen, out_span_length);
      check_field("value_offset", e.voff, out_value_offset);
      check_field("value_length", e.vlen, out_value_length);
      check_field("header_index", e.hidx, out_header_index);
      check_field("status", e.stat, out_status);
      check_field("last_of_run", e.last, out_last_of_run);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    records_seen = 0;
    headers_seen = 0;
    buffers_seen = 0;
    clear_parser();
  end

  // watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_recs.delete();
    end else begin
      if (in_valid && in_ready) predict_item(in_data_byte, in_last_byte);
      if (out_valid && out_ready) check_record();
    end
    pending = expected_recs.size();
  end

endmodule

// ===== bench/tb_http_request_header_parser_core.sv =====
`timescale 1ns / 1ps
module tb_http_request_header_parser_core;
  import hrhp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEMS_PER_MODE = 280;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_record_kind;
  logic [1:0]  out_method_code;
  logic [7:0]  out_http_major;
  logic [7:0]  out_http_minor;
  logic [15:0] out_span_offset;
  logic [15:0] out_span_length;
  logic [15:0] out_value_offset;
  logic [15:0] out_value_length;
  logic [4:0]  out_header_index;
  logic [1:0]  out_status;
  logic        out_last_of_run;

  int errors;
  int pending;
  int records_seen;
  int headers_seen;
  int buffers_seen;
  int cycles;
  int bytes_sent;
  int gap_pct;
  int stall_pct;

  byte unsigned req[$];

  http_request_header_parser_core DUT (.*);

  http_request_header_parser_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last_byte,
    .out_valid, .out_ready, .out_record_kind, .out_method_code,
    .out_http_major, .out_http_minor, .out_span_offset, .out_span_length,
    .out_value_offset, .out_value_length, .out_header_index, .out_status,
    .out_last_of_run, .errors, .pending, .records_seen, .headers_seen,
    .buffers_seen
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic add_str(string s);
    foreach (s[i]) req.push_back(s[i]);
  endtask

  task automatic add_text(int n);
    repeat (n) req.push_back(8'($urandom_range(8'h7e, 8'h21)));
  endtask

  task automatic add_digits(int n);
    repeat (n) req.push_back(8'($urandom_range(8'h39, 8'h30)));
  endtask

  task automatic add_spaces(int lo, int hi);
    repeat ($urandom_range(hi, lo)) req.push_back(CH_SP);
  endtask

  task automatic add_eol();
    req.push_back(CH_CR);
    req.push_back(CH_LF);
  endtask

  // one buffer: mostly well-formed requests, some noise and truncation
  task automatic build_request();
    int sel;
    int k;
    req.delete();
    sel = $urandom_range(19);
    if (sel < 2) begin
      repeat ($urandom_range(40, 1)) req.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(9) == 0) add_spaces(1, 2);
    case ($urandom_range(4))
      0: add_str("GET");
      1: add_str("POST");
      2: add_str("HEAD");
      3: if ($urandom_range(1)) add_str("GE");
         else add_str("POSTX");
      default: add_text($urandom_range(5, 1));
    endcase
    add_spaces(1, 3);
    req.push_back("/");
    if ($urandom_range(19) == 0) add_text($urandom_range(300, 250));
    else add_text($urandom_range(15));
    if ($urandom_range(14) == 0) begin
      req.push_back(CH_CR);
      add_text(2);
    end
    if ($urandom_range(9) != 0) begin
      add_spaces(1, 2);
      case ($urandom_range(9))
        0: add_str("HTTX/1.1");
        1: add_str("HTTP/.1");
        2: add_str("HTTP/1");
        3: add_str("HTTP/+1.1");
        4: begin
          add_str("HTTP/");
          add_digits($urandom_range(4, 1));
          req.push_back(CH_DOT);
          add_digits($urandom_range(4, 1));
          if ($urandom_range(1)) add_text(2);
        end
        default: if ($urandom_range(1)) add_str("HTTP/1.1");
                 else add_str("HTTP/1.0");
      endcase
      if ($urandom_range(9) == 0) begin
        add_spaces(1, 2);
        add_text(4);
      end
    end
    if ($urandom_range(5) == 0) add_spaces(1, 2);
    add_eol();
    k = ($urandom_range(29) == 0) ? $urandom_range(36, 33) : $urandom_range(5);
    repeat (k) begin
      if ($urandom_range(6) == 0) add_text($urandom_range(8, 1));
      else begin
        add_text($urandom_range(6));
        req.push_back(CH_COLON);
        add_spaces(0, 3);
        add_text($urandom_range(12));
        if ($urandom_range(7) == 0) req.push_back(CH_COLON);
      end
      add_eol();
    end
    if ($urandom_range(6) != 0) begin
      add_eol();
      repeat ($urandom_range(20)) req.push_back(8'($urandom_range(255)));
    end
    if (sel < 5 && req.size() > 2) req = req[0:$urandom_range(req.size() - 2)];
  endtask

  // hand one buffer to the block, last_byte on its final item
  task automatic send_buffer();
    bit rdy;
    foreach (req[i]) begin
      if ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < gap_pct);
      end
      in_valid <= 1'b1;
      in_data_byte <= req[i];
      in_last_byte <= (i == req.size() - 1);
      do begin
        @(negedge clk);
        rdy = in_ready;
        @(posedge clk);
      end while (!rdy);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    cycles = 0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full request, malformed line, no line end, lone carriage return
    req.delete();
    add_str("HEAD /x HTTP/1.1");
    add_eol();
    add_str("A:  b");
    add_eol();
    add_str("nocolon");
    add_eol();
    add_eol();
    req.push_back(8'hff);
    req.push_back(8'h00);
    send_buffer();
    req.delete();
    add_str("GET /");
    add_eol();
    add_str("x");
    send_buffer();
    req.delete();
    add_str("PUT \r/ HTTP/999.0");
    send_buffer();
    drain();

    // random traffic through the idling modes
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 60;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 60;
        end
        default: begin
          gap_pct = 16;
          stall_pct = 16;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < ITEMS_PER_MODE) begin
        build_request();
        send_buffer();
        if ($urandom_range(9) == 0) drain();
      end
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d request buffers, %0d records checked, %0d of them headers",
             buffers_seen, records_seen, headers_seen);
    $display("idling modes: none, sender gaps, receiver stalls, light gaps on both sides");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== http_request_header_parser_core.f =====
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_outq.sv
rtl/core/http_request_header_parser_core.sv
bench/http_request_header_parser_checker.sv
bench/tb_http_request_header_parser_core.sv
